>>> rtl/acr_pkg.sv
package acr_pkg;

  // Key commands
  localparam logic [3:0] CMD_TEMP   = 4'd0;
  localparam logic [3:0] CMD_MODE   = 4'd1;
  localparam logic [3:0] CMD_FAN    = 4'd2;
  localparam logic [3:0] CMD_TIMER  = 4'd3;
  localparam logic [3:0] CMD_POWER  = 4'd4;
  localparam logic [3:0] CMD_ECO    = 4'd5;
  localparam logic [3:0] CMD_SWUD   = 4'd6;
  localparam logic [3:0] CMD_SWLR   = 4'd7;
  localparam logic [3:0] CMD_ANTIBL = 4'd8;

  // Symbol kinds
  localparam logic [1:0] SYM_LEAD = 2'd0;
  localparam logic [1:0] SYM_DATA = 2'd1;
  localparam logic [1:0] SYM_STOP = 2'd2;

  // Frame constants
  localparam logic [7:0] A_SET      = 8'hB2;
  localparam logic [7:0] A_AUX      = 8'hB9;
  localparam logic [7:0] B_AUX      = 8'hAF;
  localparam logic [7:0] B_OFF      = 8'hDE;
  localparam logic [7:0] C_OFF      = 8'h07;
  localparam logic [7:0] C_ECO_ON   = 8'h24;
  localparam logic [7:0] C_ECO_OFF  = 8'hA4;
  localparam logic [7:0] C_SWUD_ON  = 8'h20;
  localparam logic [7:0] C_SWUD_OFF = 8'hA0;
  localparam logic [7:0] C_SWLR_ON  = 8'hE0;
  localparam logic [7:0] C_SWLR_OFF = 8'h10;
  localparam logic [7:0] C_ANTI_ON  = 8'hDA;
  localparam logic [7:0] C_ANTI_OFF = 8'h3A;
  localparam logic [7:0] D_HEAD     = 8'hAB;
  localparam logic [7:0] HALF_CODE  = 8'h04;

  // Symbol index of the final symbol for each transmission length
  localparam logic [4:0] LAST_LONG  = 5'd23;
  localparam logic [4:0] LAST_SHORT = 5'd15;

  localparam logic [5:0] TIMER_DEPTH = 6'd50;

  // b_high, b_low, c_high per timer half-hour count
  localparam logic [11:0] TIMER_TAB [50] = '{
    12'h850, 12'h850, 12'hC50, 12'hA50, 12'hE50, 12'h950, 12'hD50, 12'hB50,
    12'hF50, 12'h8D0, 12'hCD0, 12'hAD0, 12'hED0, 12'h9D0, 12'hDD0, 12'hBD0,
    12'hFD0, 12'h858, 12'hC58, 12'hA58, 12'hE58, 12'hE58, 12'hD58, 12'hD58,
    12'hF58, 12'hF58, 12'hCD8, 12'hCD8, 12'hED8, 12'hED8, 12'hDD8, 12'hDD8,
    12'hFD8, 12'hFD8, 12'hC54, 12'hC54, 12'hE54, 12'hE54, 12'hD54, 12'hD54,
    12'hF54, 12'hF54, 12'hCD4, 12'hCD4, 12'hED4, 12'hED4, 12'hDD4, 12'hDD4,
    12'hFD4, 12'hFD4
  };

  typedef struct packed {
    logic [3:0] cmd;
    logic [5:0] value;
  } in_t;

  typedef struct packed {
    logic [1:0] symbol_kind;
    logic [7:0] data_byte;
    logic       msb_first;
    logic       last;
  } out_t;

  // Everything the emitter needs to play one transmission
  typedef struct packed {
    logic       long_send;
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] c_inv;
    logic [7:0] fan_code;
    logic [7:0] half_code;
    logic [7:0] check_code;
  } desc_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] b_low;
    logic [7:0] code;
    logic [7:0] chk_whole;
    logic [7:0] chk_half;
  } fan_ent_t;

  function automatic fan_ent_t fan_lookup(logic [2:0] sel);
    fan_ent_t e;
    e = '{ok: 1'b1, b_low: 4'hD, code: 8'h66, chk_whole: 8'hDC, chk_half: 8'hDA};
    case (sel)
      3'd0: e = '{ok: 1'b1, b_low: 4'hD, code: 8'h66, chk_whole: 8'hDC, chk_half: 8'hDA};
      3'd1: e = '{ok: 1'b1, b_low: 4'hF, code: 8'h28, chk_whole: 8'h97, chk_half: 8'h90};
      3'd2: e = '{ok: 1'b1, b_low: 4'h9, code: 8'h14, chk_whole: 8'h97, chk_half: 8'hB8};
      3'd3: e = '{ok: 1'b1, b_low: 4'hA, code: 8'h3C, chk_whole: 8'h88, chk_half: 8'h8C};
      3'd4: e = '{ok: 1'b1, b_low: 4'hC, code: 8'h0A, chk_whole: 8'hA4, chk_half: 8'hA2};
      3'd5: e = '{ok: 1'b1, b_low: 4'hC, code: 8'h26, chk_whole: 8'hDC, chk_half: 8'hDA};
      default: e.ok = 1'b0;
    endcase
    return e;
  endfunction

  // Temperature code for whole degrees 17..30; ok low outside that span
  function automatic logic [4:0] temp_lookup(logic [4:0] whole);
    logic [4:0] r;
    r = 5'h00;
    case (whole)
      5'd17: r = {1'b1, 4'h0};
      5'd18: r = {1'b1, 4'h8};
      5'd19: r = {1'b1, 4'hC};
      5'd20: r = {1'b1, 4'h4};
      5'd21: r = {1'b1, 4'h6};
      5'd22: r = {1'b1, 4'hE};
      5'd23: r = {1'b1, 4'hA};
      5'd24: r = {1'b1, 4'h2};
      5'd25: r = {1'b1, 4'h3};
      5'd26: r = {1'b1, 4'hB};
      5'd27: r = {1'b1, 4'h9};
      5'd28: r = {1'b1, 4'h1};
      5'd29: r = {1'b1, 4'h5};
      5'd30: r = {1'b1, 4'hD};
      default: r = 5'h00;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/acr_settings.sv
module acr_settings (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          accept_i,
  input  acr_pkg::in_t  item_i,
  output logic          load_o,
  output acr_pkg::desc_t desc_o
);

  logic [5:0] temp_q, temp_d;
  logic       half_q, half_d;
  logic [2:0] fan_q, fan_d;
  logic [3:0] bh_q, bh_d, bl_q, bl_d, ch_q, ch_d, cl_q, cl_d;
  logic [7:0] fanc_q, fanc_d, halfc_q, halfc_d, chk_q, chk_d;

  logic [5:0]        tv;
  logic [4:0]        tcode;
  logic [2:0]        fan_sat;
  acr_pkg::fan_ent_t ft_keep, ft_new;
  logic [11:0]       tmr;
  logic [3:0]        frame_ch;
  logic              on;
  logic              timer_send;
  logic [7:0]        c_full;

  assign on      = item_i.value[0];
  assign tv      = (item_i.cmd == acr_pkg::CMD_TEMP) ? item_i.value : temp_q;
  assign tcode   = acr_pkg::temp_lookup(tv[5:1]);
  assign fan_sat = (item_i.value > 6'd7) ? 3'd7 : item_i.value[2:0];
  assign ft_keep = acr_pkg::fan_lookup(fan_q);
  assign ft_new  = acr_pkg::fan_lookup(fan_sat);
  assign tmr     = acr_pkg::TIMER_TAB[item_i.value];

  // Update the kept settings and build the transmission descriptor
  always_comb begin
    temp_d = temp_q; half_d = half_q; fan_d = fan_q;
    bh_d = bh_q; bl_d = bl_q; ch_d = ch_q; cl_d = cl_q;
    fanc_d = fanc_q; halfc_d = halfc_q; chk_d = chk_q;
    frame_ch   = ch_q;
    timer_send = 1'b0;
    load_o     = 1'b0;
    desc_o     = '0;
    c_full     = '0;
    desc_o.long_send = 1'b1;
    case (item_i.cmd)
      acr_pkg::CMD_TEMP, acr_pkg::CMD_POWER: begin
        if (item_i.cmd == acr_pkg::CMD_TEMP || on) begin
          if (item_i.cmd == acr_pkg::CMD_POWER) bh_d = 4'hF;
          temp_d  = tv;
          half_d  = tv[0];
          halfc_d = tv[0] ? acr_pkg::HALF_CODE : 8'h00;
          if (ft_keep.ok) begin
            bl_d   = ft_keep.b_low;
            fanc_d = ft_keep.code;
            chk_d  = tv[0] ? ft_keep.chk_half : ft_keep.chk_whole;
          end
          if (tcode[4]) cl_d = tcode[3:0];
        end else begin
          desc_o.long_send = 1'b0;
        end
        load_o = 1'b1;
      end
      acr_pkg::CMD_MODE: begin
        bh_d = 4'hF;
        case (item_i.value)
          6'd0: begin ch_d = 4'h1; bl_d = 4'h8; end
          6'd1: begin ch_d = 4'h0; bl_d = 4'hB; end
          6'd2: begin ch_d = 4'h3; bl_d = 4'hB; end
          6'd3: begin ch_d = 4'h2; bl_d = 4'h8; end
          6'd4: begin ch_d = 4'h2; bl_d = 4'hB; cl_d = 4'h7; end
          default: ;
        endcase
        frame_ch = ch_d;
        load_o   = 1'b1;
      end
      acr_pkg::CMD_FAN: begin
        fan_d = fan_sat;
        bh_d  = 4'hF;
        if (ft_new.ok) begin
          bl_d   = ft_new.b_low;
          fanc_d = ft_new.code;
          chk_d  = half_q ? ft_new.chk_half : ft_new.chk_whole;
        end
        load_o = 1'b1;
      end
      acr_pkg::CMD_TIMER: begin
        // C high nibble applies to this transmission only
        if (item_i.value < acr_pkg::TIMER_DEPTH) begin
          bh_d     = tmr[11:8];
          bl_d     = tmr[7:4];
          frame_ch = tmr[3:0];
        end
        timer_send = 1'b1;
        load_o     = 1'b1;
      end
      acr_pkg::CMD_ECO, acr_pkg::CMD_SWUD, acr_pkg::CMD_SWLR,
      acr_pkg::CMD_ANTIBL: begin
        desc_o.long_send = 1'b0;
        load_o           = 1'b1;
      end
      default: begin
        load_o = 1'b0;
      end
    endcase

    // Frame bytes
    if (desc_o.long_send) begin
      c_full       = {frame_ch, cl_d};
      desc_o.a     = acr_pkg::A_SET;
      desc_o.b     = {bh_d, bl_d};
      desc_o.c     = c_full;
      desc_o.c_inv = timer_send ? 8'hFF : ~c_full;
    end else begin
      desc_o.a = acr_pkg::A_AUX;
      desc_o.b = acr_pkg::B_AUX;
      case (item_i.cmd)
        acr_pkg::CMD_ECO:    desc_o.c = on ? acr_pkg::C_ECO_ON  : acr_pkg::C_ECO_OFF;
        acr_pkg::CMD_SWUD:   desc_o.c = on ? acr_pkg::C_SWUD_ON : acr_pkg::C_SWUD_OFF;
        acr_pkg::CMD_SWLR:   desc_o.c = on ? acr_pkg::C_SWLR_ON : acr_pkg::C_SWLR_OFF;
        acr_pkg::CMD_ANTIBL: desc_o.c = on ? acr_pkg::C_ANTI_ON : acr_pkg::C_ANTI_OFF;
        default: begin
          desc_o.a = acr_pkg::A_SET;
          desc_o.b = acr_pkg::B_OFF;
          desc_o.c = acr_pkg::C_OFF;
        end
      endcase
      desc_o.c_inv = ~desc_o.c;
    end
    desc_o.fan_code   = fanc_d;
    desc_o.half_code  = halfc_d;
    desc_o.check_code = chk_d;
  end

  // Hold the settings; advance on each accepted beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      temp_q  <= 6'd52;
      half_q  <= 1'b0;
      fan_q   <= 3'd0;
      bh_q    <= 4'd15;
      bl_q    <= 4'd0;
      ch_q    <= 4'd1;
      cl_q    <= 4'd11;
      fanc_q  <= 8'd102;
      halfc_q <= 8'd0;
      chk_q   <= 8'd220;
    end else if (accept_i) begin
      temp_q  <= temp_d;
      half_q  <= half_d;
      fan_q   <= fan_d;
      bh_q    <= bh_d;
      bl_q    <= bl_d;
      ch_q    <= ch_d;
      cl_q    <= cl_d;
      fanc_q  <= fanc_d;
      halfc_q <= halfc_d;
      chk_q   <= chk_d;
    end
  end

endmodule

>>> rtl/acr_emitter.sv
module acr_emitter (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           load_i,
  input  acr_pkg::desc_t desc_i,
  output logic           ready_o,
  output logic           busy_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output acr_pkg::out_t  out_data_o
);

  acr_pkg::desc_t desc_q;
  logic           busy_q;
  logic [4:0]     cnt_q;
  logic           out_valid_q;
  acr_pkg::out_t  out_q, sym;
  logic           adv, last_sym;
  logic [1:0]     frm;
  logic [2:0]     pos;

  assign adv      = busy_q && (!out_valid_q || !out_stall_i);
  assign last_sym = desc_q.long_send ? (cnt_q == acr_pkg::LAST_LONG)
                                     : (cnt_q == acr_pkg::LAST_SHORT);
  assign ready_o  = !busy_q || (adv && last_sym);
  assign busy_o   = busy_q;
  assign frm      = cnt_q[4:3];
  assign pos      = cnt_q[2:0];

  // Build the symbol at the current index
  always_comb begin
    sym             = '0;
    sym.last        = last_sym;
    sym.symbol_kind = acr_pkg::SYM_DATA;
    case (pos)
      3'd0: sym.symbol_kind = acr_pkg::SYM_LEAD;
      3'd7: sym.symbol_kind = acr_pkg::SYM_STOP;
      default: begin
        if (frm == 2'd2) begin
          case (pos)
            3'd1:    sym.data_byte = acr_pkg::D_HEAD;
            3'd2:    sym.data_byte = desc_q.fan_code;
            3'd3:    sym.data_byte = desc_q.half_code;
            3'd6:    sym.data_byte = desc_q.check_code;
            default: sym.data_byte = 8'h00;
          endcase
        end else begin
          case (pos)
            3'd1:    begin sym.data_byte = desc_q.a;  sym.msb_first = 1'b1; end
            3'd2:    begin sym.data_byte = ~desc_q.a; sym.msb_first = 1'b1; end
            3'd3:    sym.data_byte = desc_q.b;
            3'd4:    sym.data_byte = ~desc_q.b;
            3'd5:    sym.data_byte = desc_q.c;
            default: sym.data_byte = desc_q.c_inv;
          endcase
        end
      end
    endcase
  end

  // Load a new transmission or step through the current one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (load_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (adv && last_sym) begin
      busy_q <= 1'b0;
    end else if (adv) begin
      cnt_q <= cnt_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) desc_q <= desc_i;
  end

  // Output register: fill on advance, drop once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) out_q <= sym;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/ir_ac_remote_frame_encoder.sv
// The key beat is registered into the emitter's descriptor; its symbols then pass through the output register.
// Throughput: one symbol per cycle while the output is not stalled; 24 symbols for long
// transmissions, 16 for short ones, none for unknown commands.
// The next key is taken during the cycle the final symbol leaves the emitter.
// Reset (async, active low) restores the default settings and empties the output.
module ir_ac_remote_frame_encoder (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  acr_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output acr_pkg::out_t out_data_o
);

  logic           accept, load, ready, busy;
  acr_pkg::desc_t desc;

  assign in_stall_o = !ready;
  assign accept     = in_valid_i && !in_stall_o;

  acr_settings u_settings (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (in_data_i),
    .load_o   (load),
    .desc_o   (desc)
  );

  acr_emitter u_emitter (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept && load),
    .desc_i      (desc),
    .ready_o     (ready),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A known command starts a transmission on the next cycle
  a_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && load |=> busy)
    else $error("transmission did not start");

  // Symbol kind is never the unused code
  a_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.symbol_kind <= acr_pkg::SYM_STOP)
    else $error("bad symbol kind");

  // Lead and stop symbols carry no byte and no bit-order flag
  a_nondata: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.symbol_kind != acr_pkg::SYM_DATA |->
      out_data_o.data_byte == 8'h00 && !out_data_o.msb_first)
    else $error("non-data symbol carries payload");

  // A stalled output holds its whole symbol while a transmission is in progress
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i && busy |=> $stable(out_data_o))
    else $error("stalled symbol changed");

endmodule

>>> test/ac_frame_check_pkg.sv
`timescale 1ns / 100ps
package ac_frame_check_pkg;
  import acr_pkg::*;

  // Low C nibble per whole degree, 17 through 30
  localparam logic [3:0] TEMP_NIBBLE [14] = '{
    4'h0, 4'h8, 4'hC, 4'h4, 4'h6, 4'hE, 4'hA, 4'h2, 4'h3, 4'hB, 4'h9, 4'h1, 4'h5, 4'hD
  };

  // Per fan setting 0..5
  localparam logic [3:0] FAN_B_LOW     [6] = '{4'hD, 4'hF, 4'h9, 4'hA, 4'hC, 4'hC};
  localparam logic [7:0] FAN_CODE      [6] = '{8'h66, 8'h28, 8'h14, 8'h3C, 8'h0A, 8'h26};
  localparam logic [7:0] FAN_CHK_WHOLE [6] = '{8'hDC, 8'h97, 8'h97, 8'h88, 8'hA4, 8'hDC};
  localparam logic [7:0] FAN_CHK_HALF  [6] = '{8'hDA, 8'h90, 8'hB8, 8'h8C, 8'hA2, 8'hDA};

  // B high, B low, C high nibbles per timer half-hour count
  localparam logic [11:0] TIMER_NIBBLES [50] = '{
    12'h850, 12'h850, 12'hC50, 12'hA50, 12'hE50, 12'h950, 12'hD50, 12'hB50,
    12'hF50, 12'h8D0, 12'hCD0, 12'hAD0, 12'hED0, 12'h9D0, 12'hDD0, 12'hBD0,
    12'hFD0, 12'h858, 12'hC58, 12'hA58, 12'hE58, 12'hE58, 12'hD58, 12'hD58,
    12'hF58, 12'hF58, 12'hCD8, 12'hCD8, 12'hED8, 12'hED8, 12'hDD8, 12'hDD8,
    12'hFD8, 12'hFD8, 12'hC54, 12'hC54, 12'hE54, 12'hE54, 12'hD54, 12'hD54,
    12'hF54, 12'hF54, 12'hCD4, 12'hCD4, 12'hED4, 12'hED4, 12'hDD4, 12'hDD4,
    12'hFD4, 12'hFD4
  };

  class frame_checker;
    // Remote settings as the encoder keeps them
    logic [5:0] temp_hd;
    logic       half_on;
    logic [2:0] fan_sel;
    logic [3:0] b_hi, b_lo, c_hi, c_lo;
    logic [7:0] fan_code, half_code, chk_code;

    out_t expected_symbols [$];
    int   errors;

    function new();
      temp_hd   = 6'd52;
      half_on   = 1'b0;
      fan_sel   = 3'd0;
      b_hi      = 4'hF;
      b_lo      = 4'h0;
      c_hi      = 4'h1;
      c_lo      = 4'hB;
      fan_code  = 8'd102;
      half_code = 8'h00;
      chk_code  = 8'd220;
      errors    = 0;
    endfunction

    function int pending();
      return expected_symbols.size();
    endfunction

    function void push_symbol(logic [1:0] kind, logic [7:0] data, logic msb);
      out_t s;
      s.symbol_kind = kind;
      s.data_byte   = data;
      s.msb_first   = msb;
      s.last        = 1'b0;
      expected_symbols.push_back(s);
    endfunction

    function void push_abc(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] c_inv);
      push_symbol(SYM_LEAD, 8'h00, 1'b0);
      push_symbol(SYM_DATA, a, 1'b1);
      push_symbol(SYM_DATA, ~a, 1'b1);
      push_symbol(SYM_DATA, b, 1'b0);
      push_symbol(SYM_DATA, ~b, 1'b0);
      push_symbol(SYM_DATA, c, 1'b0);
      push_symbol(SYM_DATA, c_inv, 1'b0);
      push_symbol(SYM_STOP, 8'h00, 1'b0);
    endfunction

    function void push_short(logic [7:0] a, logic [7:0] b, logic [7:0] c);
      push_abc(a, b, c, ~c);
      push_abc(a, b, c, ~c);
    endfunction

    // Two A/B/C frames from the kept nibbles, then the D frame
    function void push_long(bit timer_send);
      logic [7:0] b, c, c_inv;
      b     = {b_hi, b_lo};
      c     = {c_hi, c_lo};
      c_inv = timer_send ? 8'hFF : ~c;
      push_abc(A_SET, b, c, c_inv);
      push_abc(A_SET, b, c, c_inv);
      push_symbol(SYM_LEAD, 8'h00, 1'b0);
      push_symbol(SYM_DATA, D_HEAD, 1'b0);
      push_symbol(SYM_DATA, fan_code, 1'b0);
      push_symbol(SYM_DATA, half_code, 1'b0);
      push_symbol(SYM_DATA, 8'h00, 1'b0);
      push_symbol(SYM_DATA, 8'h00, 1'b0);
      push_symbol(SYM_DATA, chk_code, 1'b0);
      push_symbol(SYM_STOP, 8'h00, 1'b0);
    endfunction

    // Fan codes only move while the fan setting has a table entry
    function void update_fan();
      if (fan_sel <= 3'd5) begin
        b_lo     = FAN_B_LOW[fan_sel];
        fan_code = FAN_CODE[fan_sel];
        chk_code = half_on ? FAN_CHK_HALF[fan_sel] : FAN_CHK_WHOLE[fan_sel];
      end
    endfunction

    function void update_temp(logic [5:0] v);
      logic [4:0] whole;
      whole     = v[5:1];
      temp_hd   = v;
      half_on   = v[0];
      half_code = half_on ? HALF_CODE : 8'h00;
      update_fan();
      if (whole >= 5'd17 && whole <= 5'd30) c_lo = TEMP_NIBBLE[4'(whole - 5'd17)];
    endfunction

    // Apply one accepted key beat and queue the symbols it should produce
    function void note_key(in_t k);
      int         n0;
      logic       on;
      logic [3:0] saved_c_hi;
      logic [11:0] t;
      out_t       tail;
      n0 = expected_symbols.size();
      on = k.value[0];
      case (k.cmd)
        CMD_TEMP: begin
          update_temp(k.value);
          push_long(1'b0);
        end
        CMD_MODE: begin
          b_hi = 4'hF;
          case (k.value)
            6'd0: begin c_hi = 4'h1; b_lo = 4'h8; end
            6'd1: begin c_hi = 4'h0; b_lo = 4'hB; end
            6'd2: begin c_hi = 4'h3; b_lo = 4'hB; end
            6'd3: begin c_hi = 4'h2; b_lo = 4'h8; end
            6'd4: begin c_hi = 4'h2; b_lo = 4'hB; c_lo = 4'h7; end
            default: ;
          endcase
          push_long(1'b0);
        end
        CMD_FAN: begin
          fan_sel = (k.value > 6'd7) ? 3'd7 : k.value[2:0];
          b_hi    = 4'hF;
          update_fan();
          push_long(1'b0);
        end
        CMD_TIMER: begin
          // C high is only borrowed for the timer frames
          saved_c_hi = c_hi;
          if (k.value < 6'd50) begin
            t    = TIMER_NIBBLES[k.value];
            b_hi = t[11:8];
            b_lo = t[7:4];
            c_hi = t[3:0];
          end
          push_long(1'b1);
          c_hi = saved_c_hi;
        end
        CMD_POWER: begin
          if (on) begin
            b_hi = 4'hF;
            update_temp(temp_hd);
            push_long(1'b0);
          end else begin
            push_short(A_SET, B_OFF, C_OFF);
          end
        end
        CMD_ECO:    push_short(A_AUX, B_AUX, on ? C_ECO_ON : C_ECO_OFF);
        CMD_SWUD:   push_short(A_AUX, B_AUX, on ? C_SWUD_ON : C_SWUD_OFF);
        CMD_SWLR:   push_short(A_AUX, B_AUX, on ? C_SWLR_ON : C_SWLR_OFF);
        CMD_ANTIBL: push_short(A_AUX, B_AUX, on ? C_ANTI_ON : C_ANTI_OFF);
        default: ;
      endcase
      // Mark the final symbol of this transmission
      if (expected_symbols.size() > n0) begin
        tail      = expected_symbols.pop_back();
        tail.last = 1'b1;
        expected_symbols.push_back(tail);
      end
    endfunction

    // Compare one accepted symbol beat with the oldest expectation
    function void check_symbol(out_t got);
      out_t want;
      if (expected_symbols.size() == 0) begin
        $error("unexpected symbol beat: kind %0d byte %02h msb %0b last %0b",
               got.symbol_kind, got.data_byte, got.msb_first, got.last);
        errors++;
        return;
      end
      want = expected_symbols.pop_front();
      if (got.symbol_kind !== want.symbol_kind) begin
        $error("symbol_kind: expected %0d, got %0d", want.symbol_kind, got.symbol_kind);
        errors++;
      end
      if (got.data_byte !== want.data_byte) begin
        $error("data_byte: expected %02h, got %02h", want.data_byte, got.data_byte);
        errors++;
      end
      if (got.msb_first !== want.msb_first) begin
        $error("msb_first: expected %0b, got %0b", want.msb_first, got.msb_first);
        errors++;
      end
      if (got.last !== want.last) begin
        $error("last: expected %0b, got %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

endpackage

>>> test/tb.sv
`timescale 1ns / 100ps
module tb;
  import acr_pkg::*;

  localparam int KEY_COUNT   = 360;
  localparam int CYCLE_LIMIT = 1_500_000;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_stall_i = 1'b0;
  logic in_stall_o;
  logic out_valid_o;
  out_t out_data_o;

  ac_frame_check_pkg::frame_checker sb = new();

  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;
  int recv_hold = 0;
  int unsigned cycles = 0;

  ir_ac_remote_frame_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  always #6 clk_i = ~clk_i;

  // Mostly short idles, now and then a long one
  function automatic int pick_idle(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Drive the symbol stall with runs of free and stalled cycles
  always @(posedge clk_i) begin
    if ($urandom_range(0, 399) == 0) recv_calm = ($urandom_range(0, 2) == 0);
    if (recv_hold > 0) begin
      recv_hold--;
    end else if (recv_calm || $urandom_range(0, 99) < 65) begin
      out_stall_i <= 1'b0;
      recv_hold = $urandom_range(0, 5);
    end else begin
      out_stall_i <= 1'b1;
      recv_hold = pick_idle(1'b0);
    end
  end

  // Check every accepted symbol beat
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_symbol(out_data_o);
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic in_t key_of(logic [3:0] cmd, logic [5:0] value);
    in_t k;
    k.cmd   = cmd;
    k.value = value;
    return k;
  endfunction

  // Favor values that hit the tables, keep some outside them
  function automatic in_t random_key();
    in_t k;
    int  r;
    r = $urandom_range(0, 99);
    k.cmd = (r < 8) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 8));
    r = $urandom_range(0, 99);
    case (k.cmd)
      CMD_TEMP:  k.value = (r < 80) ? 6'($urandom_range(34, 61)) : 6'($urandom_range(0, 63));
      CMD_MODE:  k.value = (r < 85) ? 6'($urandom_range(0, 4)) : 6'($urandom_range(5, 63));
      CMD_FAN:   k.value = (r < 85) ? 6'($urandom_range(0, 5)) : 6'($urandom_range(6, 63));
      CMD_TIMER: k.value = (r < 85) ? 6'($urandom_range(0, 49)) : 6'($urandom_range(50, 63));
      default:   k.value = 6'($urandom_range(0, 63));
    endcase
    return k;
  endfunction

  // Offer one key beat after an optional idle, hold it until taken
  task automatic send_key(in_t k);
    int gap;
    gap = pick_idle(send_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= k;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_key(k);
  endtask

  initial begin
    int   sent;
    int   offered;
    in_t  k;
    sent    = 0;
    offered = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: table edges, saturation, timer restore, every command
    send_key(key_of(CMD_TEMP, 6'd0));
    send_key(key_of(CMD_TEMP, 6'd63));
    send_key(key_of(CMD_TEMP, 6'd34));
    send_key(key_of(CMD_TEMP, 6'd61));
    send_key(key_of(CMD_MODE, 6'd4));
    send_key(key_of(CMD_MODE, 6'd63));
    send_key(key_of(CMD_FAN, 6'd63));
    send_key(key_of(CMD_TEMP, 6'd45));
    send_key(key_of(CMD_FAN, 6'd5));
    send_key(key_of(CMD_TIMER, 6'd0));
    send_key(key_of(CMD_TIMER, 6'd49));
    send_key(key_of(CMD_TIMER, 6'd50));
    send_key(key_of(CMD_POWER, 6'd0));
    send_key(key_of(CMD_POWER, 6'd63));
    send_key(key_of(CMD_ECO, 6'd1));
    send_key(key_of(CMD_ECO, 6'd62));
    send_key(key_of(CMD_SWUD, 6'd0));
    send_key(key_of(CMD_SWLR, 6'd1));
    send_key(key_of(CMD_ANTIBL, 6'd2));
    send_key(key_of(4'd9, 6'd21));
    send_key(key_of(4'd15, 6'd42));
    send_key(key_of(CMD_MODE, 6'd0));
    send_key(key_of(CMD_FAN, 6'd0));
    send_key(key_of(CMD_TIMER, 6'd63));
    send_key(key_of(CMD_TEMP, 6'd33));

    // Random keys; unknown commands are dropped and do not count
    while (sent < KEY_COUNT) begin
      if (offered % 30 == 0) send_calm = ($urandom_range(0, 3) == 0);
      k = random_key();
      send_key(k);
      offered++;
      if (k.cmd <= CMD_ANTIBL) sent++;
    end
    in_valid_i <= 1'b0;

    // Drain, then allow for the pipeline
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
